FILE: sv/sha1bsh_pkg.sv
`default_nettype none
package sha1bsh_pkg;

  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned RND_W      = 7;
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned LEN_BYTES  = 8;

  localparam logic [1:0] CMD_ABSORB  = 2'd0;
  localparam logic [1:0] CMD_FINISH  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word 0 sits in the top 32 bits.
  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    logic       push;
    logic       go;
    logic       init;
    logic [7:0] data;
  } ctrl_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  // Round function plus round constant.
  function automatic logic [31:0] f_plus_k(input logic [RND_W-1:0] rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    logic [31:0] k;
    if (rnd < RND_W'(20)) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < RND_W'(40)) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < RND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    return f + k;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sha1_byte_stream_hasher.sv
`default_nettype none
// SHA-1 hasher fed one byte command per input item.
// Input channel: in_command (absorb, finish, restart) and in_data_byte, with
// in_valid/in_stall. Result channel: out_digest_word, out_word_index and
// out_last_word with out_valid/out_stall; a finish yields five items, word 0
// (most significant) first, and no other command yields any.
// The byte that completes a 64-byte block starts a compression: 80 rounds on
// one round unit, then one final add, after which the sequencer sees the unit
// idle and accepts input again.
// A finish that has not yet padded pushes one pad byte per cycle, pausing for
// the compression of each full block, so 9 to 72 pad bytes plus one or two
// compressions; then the five words leave at one per cycle when the receiver
// is not stalling. A repeated finish goes straight to the five words.
// in_stall is high whenever the block is compressing, padding or sending words.
// If the receiver stalls, the current word is held until it is taken.
// Reset, or a restart item, loads the initial hash and clears the byte counts.
module sha1_byte_stream_hasher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_command,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] LAST_IDX    = 3'd4;
  localparam int unsigned FW = sha1bsh_pkg::FILL_W;

  typedef enum logic [2:0] {S_IDLE, S_COMP, S_PAD, S_PAD_COMP, S_EMIT} state_t;

  state_t        st_r;
  logic [FW-1:0] fill_r;
  logic [63:0]   count_r;
  logic          fin_r;
  logic          pad_first_r;
  logic          len_r;
  logic          last_blk_r;
  logic          out_valid_r;
  logic [2:0]    idx_r;

  sha1bsh_pkg::ctrl_t   ctrl;
  sha1bsh_pkg::stat_t   stat;
  sha1bsh_pkg::digest_t digest;

  logic        in_acc;
  logic        blk_full;
  logic        len_enter;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;

  assign in_acc    = in_valid && !in_stall;
  assign blk_full  = (fill_r == FW'(sha1bsh_pkg::BLOCK_BYTES - 1));
  assign len_enter = !pad_first_r && !len_r
                  && (fill_r == FW'(sha1bsh_pkg::BLOCK_BYTES - sha1bsh_pkg::LEN_BYTES));
  assign bit_len   = {count_r[60:0], 3'b000};

  // The length goes out big-endian, one byte per slot from offset 56 up.
  always_comb begin
    if (pad_first_r) begin
      pad_byte = sha1bsh_pkg::PAD_BYTE;
    end else if (len_r || len_enter) begin
      pad_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    ctrl = '0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_command == sha1bsh_pkg::CMD_ABSORB && !fin_r) begin
            ctrl.push = 1'b1;
            ctrl.go   = blk_full;
            ctrl.data = in_data_byte;
          end else if (in_command == sha1bsh_pkg::CMD_RESTART) begin
            ctrl.init = 1'b1;
          end
        end
      end
      S_PAD: begin
        ctrl.push = 1'b1;
        ctrl.go   = blk_full;
        ctrl.data = pad_byte;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      fin_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_r       <= 1'b0;
      last_blk_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_command)
              sha1bsh_pkg::CMD_ABSORB: begin
                if (!fin_r) begin
                  count_r <= count_r + 64'd1;
                  fill_r  <= fill_r + FW'(1);
                  if (blk_full) begin
                    st_r <= S_COMP;
                  end
                end
              end
              sha1bsh_pkg::CMD_FINISH: begin
                if (fin_r) begin
                  st_r        <= S_EMIT;
                  out_valid_r <= 1'b1;
                  idx_r       <= '0;
                end else begin
                  st_r        <= S_PAD;
                  pad_first_r <= 1'b1;
                  len_r       <= 1'b0;
                end
              end
              sha1bsh_pkg::CMD_RESTART: begin
                fill_r  <= '0;
                count_r <= '0;
                fin_r   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_COMP: begin
          if (!stat.busy) begin
            st_r <= S_IDLE;
          end
        end
        S_PAD: begin
          fill_r      <= fill_r + FW'(1);
          pad_first_r <= 1'b0;
          if (len_enter) begin
            len_r <= 1'b1;
          end
          if (blk_full) begin
            st_r       <= S_PAD_COMP;
            last_blk_r <= len_r || len_enter;
          end
        end
        S_PAD_COMP: begin
          if (!stat.busy) begin
            if (last_blk_r) begin
              fin_r       <= 1'b1;
              st_r        <= S_EMIT;
              out_valid_r <= 1'b1;
              idx_r       <= '0;
            end else begin
              st_r <= S_PAD;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (idx_r == LAST_IDX) begin
              out_valid_r <= 1'b0;
              st_r        <= S_IDLE;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  sha1bsh_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .digest (digest)
  );

  assign in_stall        = (st_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_IDX);
  assign out_digest_word = digest[3'(LAST_IDX - idx_r)];

  a_emit_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r == S_EMIT && !stat.busy && fin_r))
    else $error("digest word shown while the core is not settled");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && idx_r == LAST_IDX) |=> (!out_valid_r && st_r == S_IDLE))
    else $error("result stream did not end after the last word");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (idx_r <= LAST_IDX))
    else $error("word index out of range");

  a_pad_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PAD && blk_full) |=> stat.busy)
    else $error("padding block did not start compression");

endmodule
`default_nettype wire

FILE: sv/sha1bsh_core.sv
`default_nettype none
module sha1bsh_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  sha1bsh_pkg::ctrl_t    ctrl,
  output sha1bsh_pkg::stat_t    stat,
  output sha1bsh_pkg::digest_t  digest
);

  localparam int unsigned BB = sha1bsh_pkg::BLOCK_BITS;
  localparam int unsigned RW = sha1bsh_pkg::RND_W;

  // The byte buffer doubles as the message schedule: the oldest word is on top.
  logic [BB-1:0] sched_r, sched_nxt;
  logic [31:0]   a_r, b_r, c_r, d_r, e_r;
  logic [RW-1:0] rnd_r;
  logic          busy_r;
  sha1bsh_pkg::digest_t h_r;

  logic [31:0] w_top, w_mix, w_new, t_sum;

  assign w_top = sched_r[BB-1 -: 32];
  assign w_mix = sched_r[95:64] ^ sched_r[255:224] ^ sched_r[447:416] ^ w_top;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1bsh_pkg::f_plus_k(rnd_r, b_r, c_r, d_r)
               + e_r + w_top;

  always_comb begin
    sched_nxt = sched_r;
    if (busy_r) begin
      if (rnd_r != RW'(sha1bsh_pkg::ROUNDS)) begin
        sched_nxt = {sched_r[BB-33:0], w_new};
      end
    end else if (ctrl.push) begin
      sched_nxt = {sched_r[BB-9:0], ctrl.data};
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      h_r    <= {sha1bsh_pkg::IV0, sha1bsh_pkg::IV1, sha1bsh_pkg::IV2,
                 sha1bsh_pkg::IV3, sha1bsh_pkg::IV4};
    end else if (busy_r) begin
      if (rnd_r == RW'(sha1bsh_pkg::ROUNDS)) begin
        h_r[4] <= h_r[4] + a_r;
        h_r[3] <= h_r[3] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[1] <= h_r[1] + d_r;
        h_r[0] <= h_r[0] + e_r;
        busy_r <= 1'b0;
      end else begin
        a_r   <= t_sum;
        b_r   <= a_r;
        c_r   <= {b_r[1:0], b_r[31:2]};
        d_r   <= c_r;
        e_r   <= d_r;
        rnd_r <= rnd_r + RW'(1);
      end
    end else if (ctrl.init) begin
      h_r <= {sha1bsh_pkg::IV0, sha1bsh_pkg::IV1, sha1bsh_pkg::IV2,
              sha1bsh_pkg::IV3, sha1bsh_pkg::IV4};
    end else if (ctrl.push && ctrl.go) begin
      // The block completes with this byte; rounds begin next cycle.
      a_r    <= h_r[4];
      b_r    <= h_r[3];
      c_r    <= h_r[2];
      d_r    <= h_r[1];
      e_r    <= h_r[0];
      rnd_r  <= '0;
      busy_r <= 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign digest    = h_r;

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r <= RW'(sha1bsh_pkg::ROUNDS)))
    else $error("round counter out of range");

  a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !ctrl.init && ctrl.push && ctrl.go) |=> (busy_r && rnd_r == '0))
    else $error("compression did not start");

  a_final_add: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && rnd_r == RW'(sha1bsh_pkg::ROUNDS)) |=> !busy_r)
    else $error("compression did not finish after the final add");

endmodule
`default_nettype wire
